// ===== rtl/dip_pkg.sv =====
// Shared types, constants and helpers for the decimal integer parser.
// Used by dip_apb_regs, dip_step and decimal_integer_parser_core; no dependencies.
package dip_pkg;

  // parse phase codes
  localparam logic [1:0] PH_LEAD   = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_TRAIL  = 2'd3;

  // result status / sticky error codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // register map (index = byte address / 4)
  localparam int         CFG_ADDR_W      = 3;
  localparam logic       REG_SIGNED_MODE = 1'b0;

  localparam int         VAL_W = 64;
  localparam int         ACC_W = VAL_W + 4;  // holds magnitude * 10 + 9

  localparam logic [VAL_W-1:0] LIM_UNSIGNED = {VAL_W{1'b1}};
  localparam logic [VAL_W-1:0] LIM_POS      = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] LIM_NEG      = {1'b1, {(VAL_W-1){1'b0}}};

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic [1:0]       phase;
    logic [VAL_W-1:0] magnitude;
    logic [VAL_W-1:0] neg_mag;     // always 0 - magnitude
    logic             is_negative;
    logic [1:0]       error_code;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase:       PH_LEAD,
    magnitude:   '0,
    neg_mag:     '0,
    is_negative: 1'b0,
    error_code:  ST_OK
  };

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
            (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
  endfunction

endpackage

// ===== rtl/dip_apb_regs.sv =====
// APB-style configuration register for the decimal integer parser.
// Depends on dip_pkg.
module dip_apb_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dip_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output logic                             signed_mode
);

  logic reg_hit;
  logic wr_en;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == dip_pkg::REG_SIGNED_MODE);
  assign wr_en   = psel && penable && pwrite && pready && reg_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode <= 1'b0;
    end else if (wr_en) begin
      signed_mode <= pwdata[0];
    end
  end

  assign prdata = reg_hit ? {31'b0, signed_mode} : 32'b0;

endmodule

// ===== rtl/dip_step.sv =====
// Per-character update of the parse state and result formation.
// Depends on dip_pkg.
module dip_step (
  input  dip_pkg::parse_state_t              st,
  input  logic                               signed_mode,
  input  logic [7:0]                         char_code,
  input  logic                               char_present,
  input  logic                               is_last,
  output dip_pkg::parse_state_t              st_next,
  output logic [1:0]                         res_status,
  output logic [dip_pkg::VAL_W-1:0]          res_value
);

  logic                          is_digit;
  logic                          is_sign;
  logic                          ws;
  logic [3:0]                    dval;
  logic [dip_pkg::VAL_W-1:0]     limit;
  logic [dip_pkg::ACC_W-1:0]     mag_ext;
  logic [dip_pkg::ACC_W-1:0]     acc;
  logic [dip_pkg::VAL_W-1:0]     neg_acc;
  logic                          ovf;
  dip_pkg::parse_state_t         upd;
  logic                          take_digit;

  assign is_digit = (char_code >= dip_pkg::CH_ZERO) && (char_code <= dip_pkg::CH_NINE);
  assign is_sign  = (char_code == dip_pkg::CH_PLUS) || (char_code == dip_pkg::CH_MINUS);
  assign ws       = dip_pkg::is_ws(char_code);
  assign dval     = char_code[3:0];

  always_comb begin
    if (!signed_mode) begin
      limit = dip_pkg::LIM_UNSIGNED;
    end else if (st.is_negative) begin
      limit = dip_pkg::LIM_NEG;
    end else begin
      limit = dip_pkg::LIM_POS;
    end
  end

  // magnitude * 10 + d, exact; the negated twin tracks 0 - magnitude
  assign mag_ext = {4'b0, st.magnitude};
  assign acc     = (mag_ext << 3) + (mag_ext << 1) + {{(dip_pkg::ACC_W-4){1'b0}}, dval};
  assign neg_acc = (st.neg_mag << 3) + (st.neg_mag << 1)
                   - {{(dip_pkg::VAL_W-4){1'b0}}, dval};
  assign ovf     = acc > {4'b0, limit};

  always_comb begin
    upd        = st;
    take_digit = 1'b0;
    if (char_present && (st.error_code == dip_pkg::ST_OK)) begin
      unique case (st.phase)
        dip_pkg::PH_LEAD: begin
          if (!ws) begin
            if (is_digit) begin
              take_digit = 1'b1;
            end else if (is_sign && signed_mode) begin
              upd.is_negative = (char_code == dip_pkg::CH_MINUS);
              upd.phase       = dip_pkg::PH_SIGN;
            end else begin
              upd.error_code = dip_pkg::ST_INVALID;
            end
          end
        end
        dip_pkg::PH_SIGN: begin
          if (!ws) begin
            if (is_digit) begin
              take_digit = 1'b1;
            end else begin
              upd.error_code = dip_pkg::ST_INVALID;
            end
          end
        end
        dip_pkg::PH_DIGITS: begin
          if (is_digit) begin
            take_digit = 1'b1;
          end else if (ws) begin
            upd.phase = dip_pkg::PH_TRAIL;
          end else begin
            upd.error_code = dip_pkg::ST_INVALID;
          end
        end
        default: begin
          if (!ws) begin
            upd.error_code = dip_pkg::ST_INVALID;
          end
        end
      endcase
      if (take_digit) begin
        if (ovf) begin
          upd.error_code = dip_pkg::ST_OVERFLOW;
        end else begin
          upd.magnitude = acc[dip_pkg::VAL_W-1:0];
          upd.neg_mag   = neg_acc;
          upd.phase     = dip_pkg::PH_DIGITS;
        end
      end
    end
  end

  always_comb begin
    res_value = '0;
    if (upd.error_code != dip_pkg::ST_OK) begin
      res_status = upd.error_code;
    end else if (upd.phase == dip_pkg::PH_LEAD) begin
      res_status = dip_pkg::ST_EMPTY;
    end else if (upd.phase == dip_pkg::PH_SIGN) begin
      res_status = dip_pkg::ST_INVALID;
    end else begin
      res_status = dip_pkg::ST_OK;
      res_value  = upd.is_negative ? upd.neg_mag : upd.magnitude;
    end
  end

  // drop the per-string state once the string ends
  assign st_next = is_last ? dip_pkg::STATE_CLEAR : upd;

endmodule

// ===== rtl/decimal_integer_parser_core.sv =====
// Streaming decimal integer parser, one character per transaction.
// One character is taken every cycle unless the stage register stalls; it is
// held there, and its effect on the parse state is registered as it leaves.
// A string's result is loaded into the result register as its last item
// leaves the stage, so throughput is 1 item per cycle while results are taken.
// The cycle time is set by the accumulator update: magnitude * 10 + digit as
// one 68-bit add and compare against the active limit. A result not taken
// stalls the next string's last item and those behind it; earlier ones flow.
// Depends on dip_pkg, dip_apb_regs and dip_step.
module decimal_integer_parser_core (
  input  logic                              clk,
  input  logic                              rst,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dip_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // character channel
  input  logic                              char_valid,
  output logic                              char_ready,
  input  logic [7:0]                        char_code,
  input  logic                              char_present,
  input  logic                              is_last,
  // result channel
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [1:0]                        status,
  output logic [dip_pkg::VAL_W-1:0]         value
);

  logic                          signed_mode;

  logic                          stage_valid;
  logic [7:0]                    stage_code;
  logic                          stage_present;
  logic                          stage_last;

  logic                          out_free;
  logic                          stage_go;
  logic                          char_take;

  dip_pkg::parse_state_t         st;
  dip_pkg::parse_state_t         st_next;
  logic [1:0]                    res_status;
  logic [dip_pkg::VAL_W-1:0]     res_value;

  dip_apb_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .signed_mode (signed_mode)
  );

  dip_step u_step (
    .st           (st),
    .signed_mode  (signed_mode),
    .char_code    (stage_code),
    .char_present (stage_present),
    .is_last      (stage_last),
    .st_next      (st_next),
    .res_status   (res_status),
    .res_value    (res_value)
  );

  // a last item may move only when the result register can take it
  assign out_free   = !result_valid || result_ready;
  assign stage_go   = stage_valid && (!stage_last || out_free);
  assign char_ready = !stage_valid || stage_go;
  assign char_take  = char_valid && char_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (char_take) begin
      stage_valid <= 1'b1;
    end else if (stage_go) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_take) begin
      stage_code    <= char_code;
      stage_present <= char_present;
      stage_last    <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= dip_pkg::STATE_CLEAR;
    end else if (stage_go) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (stage_go && stage_last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && stage_last) begin
      status <= res_status;
      value  <= res_value;
    end
  end

  // value is zero on any non-ok result
  a_value_zero_unless_ok: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status != dip_pkg::ST_OK)) |-> (value == '0))
    else $error("nonzero value with non-ok status");

  // negated accumulator tracks the magnitude
  a_neg_twin: assert property (@(posedge clk) disable iff (rst)
    (dip_pkg::VAL_W'(st.magnitude + st.neg_mag) == '0))
    else $error("negated accumulator out of step");

  // a string end clears the parse state
  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (stage_go && stage_last) |=>
      ((st.phase == dip_pkg::PH_LEAD) && (st.error_code == dip_pkg::ST_OK) &&
       (st.magnitude == '0) && !st.is_negative))
    else $error("parse state not cleared after last item");

  // the first error holds until the string ends
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    ((st.error_code != dip_pkg::ST_OK) && !(stage_go && stage_last)) |=>
      (st.error_code == $past(st.error_code)))
    else $error("sticky error changed inside a string");

  // a pending result is never overwritten
  a_no_result_overrun: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |-> !(stage_go && stage_last))
    else $error("result register overrun");

endmodule
